>>> hdl/bgb_pkg.sv
// ----------------------------------------------------------------------------
// bgb_pkg: shared definitions for the bitmap glyph blitter
// Store geometry, command and status codes, and controller/datapath links.
// ----------------------------------------------------------------------------
package bgb_pkg;

  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 64;
  localparam int GLYPH_MAX   = 8;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int VW_W        = $clog2(MAX_WIDTH + 1);
  localparam int VH_W        = $clog2(MAX_HEIGHT + 1);
  localparam int XC_W        = $clog2(MAX_WIDTH);
  localparam int YC_W        = $clog2(MAX_HEIGHT);
  localparam int GC_W        = $clog2(GLYPH_MAX);
  localparam int GE_W        = 4;
  localparam int GB_W        = 64;
  localparam int GI_W        = $clog2(GB_W);
  localparam int PIX_W       = 24;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_BEGIN = 2'd1,
    FUNC_GLYPH = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_EXTENT = 2'd1,
    ST_OUTSIDE    = 2'd2
  } status_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_GLYPH,
    S_READ,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic glyph_step;
    logic rd_issue;
    logic respond;
  } ctrl_cmd_t;

  typedef struct packed {
    logic ext_ok;
    logic clr_last;
    logic glyph_last;
  } dpath_stat_t;

endpackage

>>> hdl/bgb_ctrl.sv
// ----------------------------------------------------------------------------
// bgb_ctrl: command sequencer
// Steps a command through clear, glyph paint, pixel read and response.
// ----------------------------------------------------------------------------
module bgb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  bgb_pkg::func_t      func,
  input  bgb_pkg::dpath_stat_t stat,
  output bgb_pkg::ctrl_cmd_t  cmd,
  output logic                busy
);
  import bgb_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (func)
            FUNC_CLEAR: state_next = S_CLEAR;
            FUNC_BEGIN: state_next = S_RESP;
            FUNC_GLYPH: state_next = stat.ext_ok ? S_GLYPH : S_RESP;
            FUNC_READ:  state_next = S_READ;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = S_RESP;
        end
      end
      S_GLYPH: begin
        cmd.glyph_step = 1'b1;
        if (stat.glyph_last) begin
          state_next = S_RESP;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_RESP;
      end
      S_RESP: begin
        cmd.respond = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

`ifndef SYNTHESIS
  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not leave idle");

  a_resp_returns_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_RESP |=> state == S_IDLE)
    else $error("response state did not return to idle");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.clr_step, cmd.glyph_step, cmd.rd_issue, cmd.respond}))
    else $error("more than one datapath command at once");
`endif

endmodule

>>> hdl/bgb_dpath.sv
// ----------------------------------------------------------------------------
// bgb_dpath: blitter datapath
// Command latch, pen and brush, frame store, address unit and result register.
// ----------------------------------------------------------------------------
module bgb_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  bgb_pkg::ctrl_cmd_t            cmd,
  output bgb_pkg::dpath_stat_t          stat,
  input  logic [bgb_pkg::VW_W-1:0]      vis_w,
  input  logic [bgb_pkg::VH_W-1:0]      vis_h,
  input  bgb_pkg::func_t                func,
  input  logic signed [15:0]            pos_x,
  input  logic signed [15:0]            pos_y,
  input  logic [bgb_pkg::PIX_W-1:0]     colour,
  input  logic [bgb_pkg::GB_W-1:0]      glyph_bits,
  input  logic [bgb_pkg::GE_W-1:0]      glyph_width,
  input  logic [bgb_pkg::GE_W-1:0]      glyph_height,
  input  logic                          column_major,
  output logic                          done,
  output logic [bgb_pkg::PIX_W-1:0]     pixel,
  output bgb_pkg::status_t              status
);
  import bgb_pkg::*;

  func_t              func_r;
  logic signed [15:0] arg_x;
  logic signed [15:0] arg_y;
  logic [PIX_W-1:0]   colour_r;
  logic [GB_W-1:0]    bits_r;
  logic [GE_W-1:0]    gw_r;
  logic [GE_W-1:0]    gh_r;
  logic               colmaj_r;
  logic               ext_ok_r;
  logic               rd_ok_r;
  logic [15:0]        pen_x;
  logic [15:0]        pen_y;
  logic [PIX_W-1:0]   brush;
  logic [CNT_W-1:0]   clr_cnt;
  logic [CNT_W-1:0]   clr_total;
  logic [GC_W-1:0]    gx;
  logic [GC_W-1:0]    gy;

  logic [PIX_W-1:0]   mem [STORE_DEPTH];
  logic [PIX_W-1:0]   rd_data;

  logic               ext_ok;
  logic [16:0]        sx;
  logic [16:0]        sy;
  logic               g_in;
  logic [GE_W-1:0]    col_rev;
  logic [GI_W-1:0]    bit_idx;
  logic               g_hit;
  logic               rd_ok;
  logic [XC_W-1:0]    ax;
  logic [YC_W-1:0]    ay;
  logic [ADDR_W-1:0]  addr;
  logic               clr_wr;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [PIX_W-1:0]   wdata;

  assign ext_ok = (glyph_width != '0) && (32'(glyph_width) <= GLYPH_MAX) &&
                  (glyph_height != '0) && (32'(glyph_height) <= GLYPH_MAX);

  assign sx   = {pen_x[15], pen_x} + 17'(gx);
  assign sy   = {pen_y[15], pen_y} + 17'(gy);
  assign g_in = !sx[16] && (sx[15:0] < 16'(vis_w)) &&
                !sy[16] && (sy[15:0] < 16'(vis_h));

  assign col_rev = gw_r - GE_W'(1) - GE_W'(gx);
  assign bit_idx = colmaj_r ? {gx, gy} : {gy, col_rev[GC_W-1:0]};
  assign g_hit   = g_in && bits_r[bit_idx];

  assign rd_ok = !arg_x[15] && (arg_x[15:0] < 16'(vis_w)) &&
                 !arg_y[15] && (arg_y[15:0] < 16'(vis_h));

  assign ax   = cmd.rd_issue ? arg_x[XC_W-1:0] : sx[XC_W-1:0];
  assign ay   = cmd.rd_issue ? arg_y[YC_W-1:0] : sy[YC_W-1:0];
  assign addr = ADDR_W'(ADDR_W'(ay) * ADDR_W'(vis_w)) + ADDR_W'(ax);

  assign clr_wr = cmd.clr_step && (clr_cnt < clr_total);
  assign we     = clr_wr || (cmd.glyph_step && g_hit);
  assign waddr  = cmd.clr_step ? clr_cnt[ADDR_W-1:0] : addr;
  assign wdata  = cmd.clr_step ? colour_r : brush;

  assign stat.ext_ok     = ext_ok;
  assign stat.clr_last   = (clr_cnt + CNT_W'(1)) >= clr_total;
  assign stat.glyph_last = (GE_W'(gx) == gw_r - GE_W'(1)) &&
                           (GE_W'(gy) == gh_r - GE_W'(1));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_issue) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r    <= func;
      arg_x     <= pos_x;
      arg_y     <= pos_y;
      colour_r  <= colour;
      bits_r    <= glyph_bits;
      gw_r      <= glyph_width;
      gh_r      <= glyph_height;
      colmaj_r  <= column_major;
      ext_ok_r  <= ext_ok;
      clr_total <= CNT_W'(CNT_W'(vis_w) * CNT_W'(vis_h));
    end
    if (cmd.rd_issue) begin
      rd_ok_r <= rd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x   <= '0;
      pen_y   <= '0;
      brush   <= '0;
      clr_cnt <= '0;
      gx      <= '0;
      gy      <= '0;
    end else if (cmd.load) begin
      clr_cnt <= '0;
      gx      <= '0;
      gy      <= '0;
      if (func == FUNC_BEGIN) begin
        pen_x <= $unsigned(pos_x);
        pen_y <= $unsigned(pos_y);
        brush <= colour;
      end else if (func == FUNC_GLYPH && ext_ok) begin
        pen_x <= pen_x + $unsigned(pos_x);
        pen_y <= pen_y + $unsigned(pos_y);
      end
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + CNT_W'(1);
    end else if (cmd.glyph_step) begin
      if (GE_W'(gy) == gh_r - GE_W'(1)) begin
        gy <= '0;
        gx <= gx + GC_W'(1);
      end else begin
        gy <= gy + GC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      if (func_r == FUNC_GLYPH && !ext_ok_r) begin
        pixel  <= '0;
        status <= ST_BAD_EXTENT;
      end else if (func_r == FUNC_READ && rd_ok_r) begin
        pixel  <= rd_data;
        status <= ST_OK;
      end else if (func_r == FUNC_READ) begin
        pixel  <= '0;
        status <= ST_OUTSIDE;
      end else begin
        pixel  <= '0;
        status <= ST_OK;
      end
    end
  end

endmodule

>>> hdl/bitmap_glyph_blitter_unit.sv
// ----------------------------------------------------------------------------
// bitmap_glyph_blitter_unit: glyph blitter into an RGB frame store
// Begin draw and bad glyph go straight from accept to the response state.
// Read pixel issues one store read, then responds. Glyph paints one pixel per cycle
// through the frame-store write port; clear writes each visible pixel, then responds.
// done pulses in the cycle after the response state; the receiver cannot stall.
// Reset zeroes pen and brush, sets 128x64; the store holds garbage until cleared.
// ----------------------------------------------------------------------------
module bitmap_glyph_blitter_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic [1:0]         func,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [7:0]         colour_red,
  input  logic [7:0]         colour_green,
  input  logic [7:0]         colour_blue,
  input  logic [63:0]        glyph_bits,
  input  logic [3:0]         glyph_width,
  input  logic [3:0]         glyph_height,
  input  logic               column_major,
  output logic [7:0]         pixel_red,
  output logic [7:0]         pixel_green,
  output logic [7:0]         pixel_blue,
  output logic [1:0]         status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import bgb_pkg::*;

  logic [7:0]       scr_width;
  logic [6:0]       scr_height;
  logic [VW_W-1:0]  vis_w;
  logic [VH_W-1:0]  vis_h;
  logic             cfg_wr;
  cfg_reg_t         cfg_sel;
  ctrl_cmd_t        cmd;
  dpath_stat_t      stat;
  logic [PIX_W-1:0] pixel;
  status_t          status_q;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      scr_width  <= 8'd128;
      scr_height <= 7'd64;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_WIDTH:  scr_width  <= pwdata[7:0];
        REG_HEIGHT: scr_height <= pwdata[6:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_WIDTH:  prdata = 32'(scr_width);
      REG_HEIGHT: prdata = 32'(scr_height);
    endcase
  end

  assign vis_w = (32'(scr_width) > MAX_WIDTH) ? VW_W'(MAX_WIDTH) : VW_W'(scr_width);
  assign vis_h = (32'(scr_height) > MAX_HEIGHT) ? VH_W'(MAX_HEIGHT) : VH_W'(scr_height);

  bgb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func_t'(func)),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  bgb_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .vis_w        (vis_w),
    .vis_h        (vis_h),
    .func         (func_t'(func)),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .colour       ({colour_red, colour_green, colour_blue}),
    .glyph_bits   (glyph_bits),
    .glyph_width  (glyph_width),
    .glyph_height (glyph_height),
    .column_major (column_major),
    .done         (done),
    .pixel        (pixel),
    .status       (status_q)
  );

  assign pixel_red   = pixel[23:16];
  assign pixel_green = pixel[15:8];
  assign pixel_blue  = pixel[7:0];
  assign status      = status_q;

endmodule

>>> tb/sv/bitmap_glyph_blitter_unit_test.sv
// ----------------------------------------------------------------------------
// bitmap_glyph_blitter_unit_test: self-checking bench for the glyph blitter
// Drives clear, begin-draw, glyph and read commands through the start/busy
// port and reprograms the screen size over APB between phases. A scoreboard
// keeps its own copy of the frame, pen and brush and checks every strobed
// result field by field against the predicted pixel and status.
// ----------------------------------------------------------------------------
module bitmap_glyph_blitter_unit_test;
  import bgb_pkg::*;

  localparam int CYCLE_LIMIT = 20_000_000;

  typedef struct {
    func_t             func;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [63:0]       glyph_bits;
    logic [3:0]        glyph_width;
    logic [3:0]        glyph_height;
    logic              column_major;
  } blit_cmd_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    status_t    status;
  } blit_result_t;

  class blit_tracker;
    logic [23:0]  pixels [STORE_DEPTH];
    bit           painted [STORE_DEPTH];
    logic [15:0]  pen_x;
    logic [15:0]  pen_y;
    logic [23:0]  brush;
    logic [7:0]   width_reg;
    logic [6:0]   height_reg;
    blit_result_t pending [$];
    int           mismatches;

    function new();
      pen_x = '0;
      pen_y = '0;
      brush = '0;
      width_reg = 8'd128;
      height_reg = 7'd64;
      mismatches = 0;
    endfunction

    function int vis_w();
      return (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    endfunction

    function int vis_h();
      return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    endfunction

    function bit in_screen(int x, int y);
      return x >= 0 && y >= 0 && x < vis_w() && y < vis_h();
    endfunction

    function bit pixel_known(int x, int y);
      return !in_screen(x, y) || painted[y * vis_w() + x];
    endfunction

    function void set_reg(cfg_reg_t which, logic [31:0] value);
      if (which == REG_WIDTH) begin
        width_reg = value[7:0];
      end else begin
        height_reg = value[6:0];
      end
    endfunction

    function void take_command(blit_cmd_t c);
      blit_result_t res;
      int w, h, idx, gx, gy, ox, oy, sx, sy, bitpos;
      logic [7:0] glyph_byte;
      w = vis_w();
      h = vis_h();
      res = '{8'd0, 8'd0, 8'd0, ST_OK};
      case (c.func)
        FUNC_CLEAR: begin
          for (idx = 0; idx < w * h; idx++) begin
            pixels[idx] = {c.red, c.green, c.blue};
            painted[idx] = 1'b1;
          end
        end
        FUNC_BEGIN: begin
          pen_x = c.pos_x;
          pen_y = c.pos_y;
          brush = {c.red, c.green, c.blue};
        end
        FUNC_GLYPH: begin
          if (c.glyph_width == 0 || c.glyph_width > GLYPH_MAX ||
              c.glyph_height == 0 || c.glyph_height > GLYPH_MAX) begin
            res.status = ST_BAD_EXTENT;
          end else begin
            pen_x = pen_x + c.pos_x;
            pen_y = pen_y + c.pos_y;
            ox = int'($signed(pen_x));
            oy = int'($signed(pen_y));
            for (gx = 0; gx < c.glyph_width; gx++) begin
              for (gy = 0; gy < c.glyph_height; gy++) begin
                sx = ox + gx;
                sy = oy + gy;
                if (in_screen(sx, sy)) begin
                  if (c.column_major) begin
                    glyph_byte = c.glyph_bits[8 * gx +: 8];
                    bitpos = gy;
                  end else begin
                    glyph_byte = c.glyph_bits[8 * gy +: 8];
                    bitpos = int'(c.glyph_width) - 1 - gx;
                  end
                  if (glyph_byte[bitpos]) begin
                    pixels[sy * w + sx] = brush;
                    painted[sy * w + sx] = 1'b1;
                  end
                end
              end
            end
          end
        end
        FUNC_READ: begin
          if (!in_screen(int'(c.pos_x), int'(c.pos_y))) begin
            res.status = ST_OUTSIDE;
          end else begin
            {res.red, res.green, res.blue} = pixels[int'(c.pos_y) * w + int'(c.pos_x)];
          end
        end
      endcase
      pending.push_back(res);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void match_result(blit_result_t got);
      blit_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing pending, expected none got %0h %0h %0h %0h",
                 $time, got.red, got.green, got.blue, got.status);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      compare_field("pixel_red", int'(want.red), int'(got.red));
      compare_field("pixel_green", int'(want.green), int'(got.green));
      compare_field("pixel_blue", int'(want.blue), int'(got.blue));
      compare_field("status", int'(want.status), int'(got.status));
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               done;
  logic [1:0]         func;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [7:0]         colour_red;
  logic [7:0]         colour_green;
  logic [7:0]         colour_blue;
  logic [63:0]        glyph_bits;
  logic [3:0]         glyph_width;
  logic [3:0]         glyph_height;
  logic               column_major;
  logic [7:0]         pixel_red;
  logic [7:0]         pixel_green;
  logic [7:0]         pixel_blue;
  logic [1:0]         status;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  blit_tracker tracker;
  int          cycle_count;
  int          no_gap_left;

  int phase_w [10] = '{16, 1, 0, 128, 255, 37, 128, 1, 8, 128};
  int phase_h [10] = '{8, 1, 64, 0, 127, 23, 1, 64, 5, 64};

  bitmap_glyph_blitter_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .func         (func),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .colour_red   (colour_red),
    .colour_green (colour_green),
    .colour_blue  (colour_blue),
    .glyph_bits   (glyph_bits),
    .glyph_width  (glyph_width),
    .glyph_height (glyph_height),
    .column_major (column_major),
    .pixel_red    (pixel_red),
    .pixel_green  (pixel_green),
    .pixel_blue   (pixel_blue),
    .status       (status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bitmap_glyph_blitter_unit_test: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && done === 1'b1) begin
      tracker.match_result('{pixel_red, pixel_green, pixel_blue, status_t'(status)});
    end
  end

  function automatic blit_cmd_t make_cmd(func_t f, int x, int y, logic [23:0] rgb,
                                         logic [63:0] bits, int gw, int gh, bit cm);
    blit_cmd_t c;
    c.func = f;
    c.pos_x = 16'(x);
    c.pos_y = 16'(y);
    {c.red, c.green, c.blue} = rgb;
    c.glyph_bits = bits;
    c.glyph_width = 4'(gw);
    c.glyph_height = 4'(gh);
    c.column_major = cm;
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gap_left > 0) begin
      no_gap_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      no_gap_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic blit_cmd_t rand_cmd();
    blit_cmd_t c;
    int r, vw, vh, x, y, tx, ty;
    vw = tracker.vis_w();
    vh = tracker.vis_h();
    c.pos_x = 16'($urandom);
    c.pos_y = 16'($urandom);
    c.red = 8'($urandom);
    c.green = 8'($urandom);
    c.blue = 8'($urandom);
    c.glyph_bits = {$urandom, $urandom};
    c.glyph_width = 4'($urandom_range(1, GLYPH_MAX));
    c.glyph_height = 4'($urandom_range(1, GLYPH_MAX));
    c.column_major = 1'($urandom);
    r = $urandom_range(0, 99);
    if (r < 2) begin
      c.func = FUNC_CLEAR;
    end else if (r < 17) begin
      c.func = FUNC_BEGIN;
      if ($urandom_range(0, 9) < 8) begin
        c.pos_x = 16'(int'($urandom_range(0, vw + 10)) - 8);
        c.pos_y = 16'(int'($urandom_range(0, vh + 10)) - 8);
      end
    end else if (r < 67) begin
      c.func = FUNC_GLYPH;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        c.pos_x = 16'(int'($urandom_range(0, 8)) - 4);
        c.pos_y = 16'(int'($urandom_range(0, 8)) - 4);
      end else if (r < 70) begin
        c.pos_x = '0;
        c.pos_y = '0;
      end else if (r < 85) begin
        tx = int'($urandom_range(0, vw + 6)) - 6;
        ty = int'($urandom_range(0, vh + 6)) - 6;
        c.pos_x = 16'(tx - int'($signed(tracker.pen_x)));
        c.pos_y = 16'(ty - int'($signed(tracker.pen_y)));
      end
      if ($urandom_range(0, 99) < 10) begin
        c.glyph_width = 4'($urandom);
        c.glyph_height = 4'($urandom);
      end
      r = $urandom_range(0, 9);
      if (r == 0) begin
        c.glyph_bits = '1;
      end else if (r == 1) begin
        c.glyph_bits = 64'd1 << $urandom_range(0, 63);
      end
    end else begin
      c.func = FUNC_READ;
      r = $urandom_range(0, 99);
      if (r < 60 && vw > 0 && vh > 0) begin
        x = int'($urandom_range(0, vw - 1));
        y = int'($urandom_range(0, vh - 1));
      end else if (r < 85) begin
        x = int'($signed(tracker.pen_x)) + int'($urandom_range(0, 9)) - 1;
        y = int'($signed(tracker.pen_y)) + int'($urandom_range(0, 9)) - 1;
      end else begin
        x = int'(c.pos_x);
        y = int'(c.pos_y);
      end
      if (!tracker.pixel_known(x, y)) x = -int'($urandom_range(1, 32768));
      c.pos_x = 16'(x);
      c.pos_y = 16'(y);
    end
    return c;
  endfunction

  task automatic issue(blit_cmd_t c);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    func <= c.func;
    pos_x <= c.pos_x;
    pos_y <= c.pos_y;
    colour_red <= c.red;
    colour_green <= c.green;
    colour_blue <= c.blue;
    glyph_bits <= c.glyph_bits;
    glyph_width <= c.glyph_width;
    glyph_height <= c.glyph_height;
    column_major <= c.column_major;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.take_command(c);
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t which, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    tracker.set_reg(which, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic run_directed();
    issue(make_cmd(FUNC_CLEAR, 0, 0, 24'h123456, '0, 0, 0, 0));
    issue(make_cmd(FUNC_READ, 0, 0, '0, '0, 0, 0, 0));
    issue(make_cmd(FUNC_READ, 127, 63, '0, '0, 0, 0, 0));
    issue(make_cmd(FUNC_READ, 128, 0, '0, '0, 0, 0, 0));
    issue(make_cmd(FUNC_READ, 0, 64, '0, '0, 0, 0, 0));
    issue(make_cmd(FUNC_READ, -1, 0, '0, '0, 0, 0, 0));
    issue(make_cmd(FUNC_READ, -32768, 32767, '0, '0, 0, 0, 0));
    issue(make_cmd(FUNC_BEGIN, 0, 0, 24'hFFFFFF, '0, 0, 0, 0));
    issue(make_cmd(FUNC_GLYPH, 0, 0, '0, '1, 8, 8, 0));
    issue(make_cmd(FUNC_READ, 7, 7, '0, '0, 0, 0, 0));
    issue(make_cmd(FUNC_BEGIN, 124, 60, 24'h8001FE, '0, 0, 0, 0));
    issue(make_cmd(FUNC_GLYPH, 0, 0, '0, 64'h8142_2418_1824_4281, 8, 8, 0));
    issue(make_cmd(FUNC_READ, 127, 63, '0, '0, 0, 0, 0));
    issue(make_cmd(FUNC_GLYPH, -126, -62, '0, 64'h0000_0007_0502_0607, 5, 3, 1));
    issue(make_cmd(FUNC_READ, 0, 0, '0, '0, 0, 0, 0));
    issue(make_cmd(FUNC_READ, 2, 0, '0, '0, 0, 0, 0));
    issue(make_cmd(FUNC_GLYPH, 5, 5, '0, '1, 0, 4, 0));
    issue(make_cmd(FUNC_GLYPH, 5, 5, '0, '1, 9, 8, 1));
    issue(make_cmd(FUNC_GLYPH, 5, 5, '0, '1, 8, 15, 0));
    issue(make_cmd(FUNC_GLYPH, 3, 3, '0, 64'h1, 1, 1, 0));
    issue(make_cmd(FUNC_READ, 1, 1, '0, '0, 0, 0, 0));
    issue(make_cmd(FUNC_BEGIN, 32767, 32767, 24'h000000, '0, 0, 0, 0));
    issue(make_cmd(FUNC_GLYPH, 1, 1, '0, '1, 8, 8, 1));
    issue(make_cmd(FUNC_READ, 0, 0, '0, '0, 0, 0, 0));
  endtask

  initial begin
    tracker = new();
    cycle_count = 0;
    no_gap_left = 0;
    rst = 1'b1;
    start = 1'b0;
    func = FUNC_CLEAR;
    pos_x = '0;
    pos_y = '0;
    colour_red = '0;
    colour_green = '0;
    colour_blue = '0;
    glyph_bits = '0;
    glyph_width = '0;
    glyph_height = '0;
    column_major = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    for (int p = 0; p < 10; p++) begin
      wait_quiet();
      write_reg(REG_WIDTH, phase_w[p]);
      write_reg(REG_HEIGHT, phase_h[p]);
      issue(make_cmd(FUNC_CLEAR, 0, 0, 24'($urandom), '0, 0, 0, 0));
      for (int n = 0; n < 164; n++) begin
        if ($urandom_range(0, 99) == 0) wait_quiet();
        issue(rand_cmd());
      end
    end
    wait_quiet();

    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("bitmap_glyph_blitter_unit_test: clean");
    end else begin
      $display("bitmap_glyph_blitter_unit_test: errors");
    end
    $finish;
  end

endmodule
